// ----- hdl/multi_channel_duplex_byte_fifo_core_macros.svh -----
// Assertion helpers for the checks in the core module.
`ifndef MULTI_CHANNEL_DUPLEX_BYTE_FIFO_CORE_MACROS_SVH
`define MULTI_CHANNEL_DUPLEX_BYTE_FIFO_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MCDBF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MCDBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/mcdbf_pkg.sv -----
package mcdbf_pkg;

    // Default build
    localparam int CHANNELS_DEF    = 8;
    localparam int QUEUE_DEPTH_DEF = 2048;
    localparam int MAX_READ_DEF    = 64;

    // Fixed field widths
    localparam int CMD_W   = 3;
    localparam int CH_W    = 4;
    localparam int CHOUT_W = 3;
    localparam int LIMIT_W = 7;
    localparam int CNT_W   = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC    = 3'd0,
        CMD_M_WRITE  = 3'd1,
        CMD_S_WRITE  = 3'd2,
        CMD_M_READ   = 3'd3,
        CMD_S_READ   = 3'd4,
        CMD_COUNTERS = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NO_FREE = 2'd2,
        ST_DROPPED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_START,
        S_RD_STREAM
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [CH_W-1:0]    channel;
        logic [7:0]         data_in;
        logic               has_byte;
        logic               first_of_call;
        logic [LIMIT_W-1:0] read_limit;
    } t_in_beat;

    typedef struct packed {
        t_status            status;
        logic [CHOUT_W-1:0] channel_out;
        logic [7:0]         data_out;
        logic               data_valid;
        logic               last;
        logic [CNT_W-1:0]   dropped_total;
        logic [CNT_W-1:0]   invalid_total;
    } t_out_beat;

    // Pointer table update request
    typedef struct packed {
        logic alloc;
        logic wr_inc;
        logic rd_inc;
    } t_ptab_op;

    // Saturating counter step
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

endpackage

// ----- hdl/multi_channel_duplex_byte_fifo_core.sv -----
// Channel  Direction  Beat type   Handshake
// in       to core    t_in_beat   i_in_valid / o_in_stall
// out      from core  t_out_beat  o_out_valid / i_out_stall
//
// Alloc, write and counter beats can stream back to back while the output is not stalled.
// A read holds the input while it runs: a start state, then one byte per cycle
// through the byte store's read port while the output is not stalled.
// Reset clears the channel claims, pointers and counters at once; no sweep.
// A stalled output register holds the input stall as well; bytes never queue.
`include "multi_channel_duplex_byte_fifo_core_macros.svh"

module multi_channel_duplex_byte_fifo_core #(
    parameter int CHANNELS    = mcdbf_pkg::CHANNELS_DEF,
    parameter int QUEUE_DEPTH = mcdbf_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_READ    = mcdbf_pkg::MAX_READ_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mcdbf_pkg::t_in_beat  i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mcdbf_pkg::t_out_beat o_out_beat
);
    import mcdbf_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QW = CW + 1;
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int AW = QW + PW;
    localparam int RW = $clog2(MAX_READ + 1);

    t_state           r_state, n_state;
    t_out_beat        r_out, n_out;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_drop, n_drop;
    logic [CNT_W-1:0] r_inv, n_inv;
    logic [QW-1:0]    r_q, n_q;
    logic [RW-1:0]    r_rem, n_rem;
    logic             r_last, n_last;

    logic             out_free, out_load, accept;
    logic             in_dir, empty, rd_done;
    logic [QW-1:0]    in_q, q_sel;
    logic [LIMIT_W-1:0] lim;
    t_ptab_op         op;
    logic             ch_ok, free_found;
    logic [CH_W-1:0]  free_idx;
    logic [PW-1:0]    wr_ptr, rd_ptr, wr_next, rd_next;
    logic             mem_we, mem_re;
    logic [7:0]       mem_rdata;

    // Handshake
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && out_free);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // Queue select: odd queue is slave-to-master
    assign in_dir = i_in_beat.command inside {CMD_S_WRITE, CMD_M_READ};
    assign in_q   = {i_in_beat.channel[CW-1:0], in_dir};
    assign q_sel  = (r_state == S_IDLE) ? in_q : r_q;
    assign lim    = (i_in_beat.read_limit > LIMIT_W'(MAX_READ)) ?
                    LIMIT_W'(MAX_READ) : i_in_beat.read_limit;
    assign empty   = (rd_ptr == wr_ptr);
    assign rd_done = (r_rem == '0) || empty;

    mcdbf_ptab #(
        .CHANNELS    (CHANNELS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CW          (CW),
        .QW          (QW),
        .PW          (PW)
    ) u_ptab (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_q          (q_sel),
        .i_ch         (i_in_beat.channel),
        .o_ch_ok      (ch_ok),
        .o_wr_ptr     (wr_ptr),
        .o_rd_ptr     (rd_ptr),
        .o_wr_next    (wr_next),
        .o_rd_next    (rd_next),
        .o_free_found (free_found),
        .o_free_idx   (free_idx)
    );

    mcdbf_qstore #(
        .AW (AW)
    ) u_qstore (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr ({in_q, wr_ptr}),
        .i_wdata (i_in_beat.data_in),
        .i_re    (mem_re),
        .i_raddr ({r_q, rd_ptr}),
        .o_rdata (mem_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && ch_ok &&
                    (i_in_beat.command inside {CMD_M_READ, CMD_S_READ})) begin
                    n_state = S_RD_START;
                end
            end
            S_RD_START: begin
                if (!rd_done) begin
                    n_state = S_RD_STREAM;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_RD_STREAM: begin
                if (out_free && r_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and result beats
    always_comb begin
        out_load = 1'b0;
        op       = '0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        n_drop   = r_drop;
        n_inv    = r_inv;
        n_q      = r_q;
        n_rem    = r_rem;
        n_last   = r_last;
        n_out               = r_out;
        n_out.status        = ST_OK;
        n_out.channel_out   = '0;
        n_out.data_out      = '0;
        n_out.data_valid    = 1'b0;
        n_out.last          = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_beat.command)
                        CMD_ALLOC: begin
                            out_load = 1'b1;
                            if (free_found) begin
                                op.alloc          = 1'b1;
                                n_out.channel_out = free_idx[CHOUT_W-1:0];
                            end else begin
                                n_out.status = ST_NO_FREE;
                            end
                        end
                        CMD_M_WRITE, CMD_S_WRITE: begin
                            out_load = 1'b1;
                            if (!ch_ok) begin
                                n_out.status = ST_INVALID;
                                if (i_in_beat.first_of_call) begin
                                    n_inv = sat_inc(r_inv);
                                end
                            end else if (i_in_beat.has_byte) begin
                                if (wr_next == rd_ptr) begin
                                    n_out.status = ST_DROPPED;
                                    n_drop       = sat_inc(r_drop);
                                end else begin
                                    mem_we    = 1'b1;
                                    op.wr_inc = 1'b1;
                                end
                            end
                        end
                        CMD_M_READ, CMD_S_READ: begin
                            if (!ch_ok) begin
                                out_load     = 1'b1;
                                n_out.status = ST_INVALID;
                                n_inv        = sat_inc(r_inv);
                            end else begin
                                n_q   = in_q;
                                n_rem = RW'(lim);
                            end
                        end
                        default: out_load = 1'b1;
                    endcase
                end
            end
            S_RD_START: begin
                if (rd_done) begin
                    // nothing to drain: single empty beat
                    out_load = out_free;
                end else begin
                    mem_re    = 1'b1;
                    op.rd_inc = 1'b1;
                    n_last    = (r_rem == RW'(1)) || (rd_next == wr_ptr);
                    n_rem     = r_rem - 1'b1;
                end
            end
            S_RD_STREAM: begin
                if (out_free) begin
                    out_load         = 1'b1;
                    n_out.data_out   = mem_rdata;
                    n_out.data_valid = 1'b1;
                    n_out.last       = r_last;
                    // overlap the next fetch with this beat
                    if (!r_last) begin
                        mem_re    = 1'b1;
                        op.rd_inc = 1'b1;
                        n_last    = (r_rem == RW'(1)) || (rd_next == wr_ptr);
                        n_rem     = r_rem - 1'b1;
                    end
                end
            end
            default: ;
        endcase

        n_out.dropped_total = n_drop;
        n_out.invalid_total = n_inv;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_drop      <= '0;
            r_inv       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= out_load || (r_out_valid && i_out_stall);
            r_drop      <= n_drop;
            r_inv       <= n_inv;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_last <= n_last;
        if (out_load) begin
            r_out <= n_out;
        end
    end

    // Checks
    `MCDBF_ASSERT_NOW(a_no_rw_overlap, i_clk, i_rst_n, mem_we, !mem_re,
                      "store read and write overlap")
    `MCDBF_ASSERT_NOW(a_stream_has_data, i_clk, i_rst_n,
                      (r_state == S_RD_STREAM) && !r_last, !empty,
                      "read stream past queue end")
    `MCDBF_ASSERT_NEXT(a_counters_monotonic, i_clk, i_rst_n, 1'b1,
                       (r_drop >= $past(r_drop)) && (r_inv >= $past(r_inv)),
                       "counter went down")

endmodule

// ----- hdl/mcdbf_qstore.sv -----
module mcdbf_qstore #(
    parameter int AW = 15
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [2**AW];
    logic [7:0] r_rdata;

    // Byte store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/mcdbf_ptab.sv -----
module mcdbf_ptab #(
    parameter int CHANNELS    = 8,
    parameter int QUEUE_DEPTH = 2048,
    parameter int CW          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    parameter int QW          = CW + 1,
    parameter int PW          = $clog2(QUEUE_DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mcdbf_pkg::t_ptab_op       i_op,
    input  logic [QW-1:0]             i_q,
    input  logic [mcdbf_pkg::CH_W-1:0] i_ch,
    output logic                      o_ch_ok,
    output logic [PW-1:0]             o_wr_ptr,
    output logic [PW-1:0]             o_rd_ptr,
    output logic [PW-1:0]             o_wr_next,
    output logic [PW-1:0]             o_rd_next,
    output logic                      o_free_found,
    output logic [mcdbf_pkg::CH_W-1:0] o_free_idx
);
    import mcdbf_pkg::*;

    localparam int NSLOT = 2**CW;
    localparam int NQ    = 2**QW;

    logic [PW-1:0]    r_wr_ptr [NQ];
    logic [PW-1:0]    r_rd_ptr [NQ];
    logic [NSLOT-1:0] r_in_use;

    function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Lowest free channel
    always_comb begin
        o_free_found = 1'b0;
        o_free_idx   = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                o_free_found = 1'b1;
                o_free_idx   = CH_W'(i);
            end
        end
    end

    // Channel check and pointer lookup
    assign o_ch_ok   = ({1'b0, i_ch} < (CH_W + 1)'(CHANNELS)) && r_in_use[i_ch[CW-1:0]];
    assign o_wr_ptr  = r_wr_ptr[i_q];
    assign o_rd_ptr  = r_rd_ptr[i_q];
    assign o_wr_next = wrap_next(r_wr_ptr[i_q]);
    assign o_rd_next = wrap_next(r_rd_ptr[i_q]);

    // Claim clears both queues of a channel; otherwise step one pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
            for (int j = 0; j < NQ; j++) begin
                r_wr_ptr[j] <= '0;
                r_rd_ptr[j] <= '0;
            end
        end else begin
            if (i_op.alloc) begin
                r_in_use[o_free_idx[CW-1:0]] <= 1'b1;
            end
            for (int j = 0; j < NQ; j++) begin
                if (i_op.alloc && (QW'(j) >> 1) == QW'(o_free_idx[CW-1:0])) begin
                    r_wr_ptr[j] <= '0;
                    r_rd_ptr[j] <= '0;
                end else if (QW'(j) == i_q) begin
                    if (i_op.wr_inc) begin
                        r_wr_ptr[j] <= o_wr_next;
                    end
                    if (i_op.rd_inc) begin
                        r_rd_ptr[j] <= o_rd_next;
                    end
                end
            end
        end
    end

endmodule
